[rtl/core/ftbr_pkg.sv]
// Shared constants and types for the float to best rational converter.
`timescale 1ns / 1ps
`default_nettype none

package ftbr_pkg;

   typedef logic [62:0] dbl_mag_type;
   typedef logic [52:0] mant_type;
   typedef logic signed [12:0] exp_type;
   typedef logic [30:0] den_type;

   localparam int MANT_BITS = 53;
   localparam int QUO_BITS = 55;
   localparam int TERM_BITS = 33;

   localparam logic [10:0] EXP_BIAS = 11'd1023;
   localparam exp_type EXP_BIAS_S = 13'sd1023;
   localparam logic [10:0] EXP_HUGE = 11'd1055;
   localparam dbl_mag_type MAG_LIMIT = 63'h41E0000000000000;
   localparam dbl_mag_type EPS_REMAINDER = 63'h3DDB7CDFD9D7BDBB;
   localparam logic [TERM_BITS-1:0] TERM_CLAMP = 33'h100000000;
   localparam den_type DEN_RESET = 31'd1000000;

endpackage

`default_nettype wire

[rtl/core/ftbr_norm.sv]
// Normalize and round unit: shifts a 64-bit value left to its leading one, rounds to a double.
`timescale 1ns / 1ps
`default_nettype none

module ftbr_norm (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [63:0]         in_value,
   input  wire ftbr_pkg::exp_type   in_exp,
   output logic                     done,
   output ftbr_pkg::dbl_mag_type    result
);
   import ftbr_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] val_ff, val_in;
   exp_type     exp_ff, exp_in;
   dbl_mag_type res_ff, res_in;

   logic [52:0] mant;
   logic        rnd_up;
   logic [53:0] msum;
   logic [52:0] mfin;
   exp_type     efin;
   exp_type     ebiased;

   always_comb begin
      mant = val_ff[63:11];
      rnd_up = val_ff[10] & ((|val_ff[9:0]) | val_ff[11]);
      msum = {1'b0, mant} + {53'd0, rnd_up};
      if (msum[53]) begin
         mfin = msum[53:1];
         efin = exp_ff + 13'sd1;
      end else begin
         mfin = msum[52:0];
         efin = exp_ff;
      end
      ebiased = efin + EXP_BIAS_S;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      val_in = val_ff;
      exp_in = exp_ff;
      res_in = res_ff;
      if (start) begin
         busy_in = 1'b1;
         val_in = in_value;
         exp_in = in_exp;
      end else if (busy_ff) begin
         if (val_ff == 64'd0) begin
            res_in = '0;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else if (!val_ff[63]) begin
            val_in = {val_ff[62:0], 1'b0};
            exp_in = exp_ff - 13'sd1;
         end else begin
            res_in = {ebiased[10:0], mfin[51:0]};
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff <= val_in;
      exp_ff <= exp_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

[rtl/core/ftbr_div.sv]
// Restoring mantissa divider: one quotient bit per cycle plus remainder sticky.
`timescale 1ns / 1ps
`default_nettype none

module ftbr_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire ftbr_pkg::mant_type  num_mant,
   input  wire ftbr_pkg::mant_type  den_mant,
   output logic                     done,
   output logic [54:0]              quotient,
   output logic                     sticky
);
   import ftbr_pkg::*;

   localparam logic [5:0] LAST_STEP = 6'(QUO_BITS - 1);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [54:0] rem_ff, rem_in;
   mant_type    den_ff, den_in;
   logic [54:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic        ge;
   logic [54:0] rdiff;

   always_comb begin
      ge = rem_ff >= {2'b00, den_ff};
      rdiff = ge ? (rem_ff - {2'b00, den_ff}) : rem_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in = {2'b00, num_mant};
         den_in = den_mant;
         cnt_in = '0;
      end else if (busy_ff) begin
         rem_in = {rdiff[53:0], 1'b0};
         quo_in = {quo_ff[53:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign sticky = |rem_ff;

endmodule

`default_nettype wire

[rtl/core/ftbr_mac.sv]
// Shift-add multiply-accumulate: term times a 64-bit operand plus addend, modulo 2^64.
`timescale 1ns / 1ps
`default_nettype none

module ftbr_mac (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [32:0]  mul_a,
   input  wire logic [63:0]  mul_b,
   input  wire logic [63:0]  add_c,
   output logic              done,
   output logic [63:0]       result
);
   import ftbr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [63:0]          acc_ff, acc_in;
   logic [63:0]          mb_ff, mb_in;
   logic [TERM_BITS-1:0] ma_ff, ma_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in = acc_ff;
      mb_in = mb_ff;
      ma_in = ma_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in = add_c;
         mb_in = mul_b;
         ma_in = mul_a;
      end else if (busy_ff) begin
         if (ma_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (ma_ff[0]) begin
               acc_in = acc_ff + mb_ff;
            end
            mb_in = {mb_ff[62:0], 1'b0};
            ma_in = {1'b0, ma_ff[TERM_BITS-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      mb_ff <= mb_in;
      ma_ff <= ma_in;
   end

   assign done = done_ff;
   assign result = acc_ff;

endmodule

`default_nettype wire

[rtl/core/float_to_best_rational.sv]
// Top level: continued-fraction best rational approximation of an IEEE double.
//
// Raise start with req_value_bits while busy is low; the request is taken at
// that edge and busy stays high until the result has been issued. The result
// appears on rsp_numerator, rsp_denominator and rsp_error with rsp_strobe
// high for exactly one cycle; the receiver cannot stall it.
// Each continued-fraction term runs on three shared units under one
// sequencer: a normalize/round unit (one bit shift per cycle), a
// restoring divider and a shift-add multiplier that steps through the
// bits of the term. A denominator overflow adds a tail that compares
// the last two convergents.
// Error inputs (non-finite or magnitude at least 2^31) go straight to
// the done state, which strobes their result.
// csr_wdata is written to the denominator limit when csr_wen is high; write it
// only while busy is low. Reset returns the limit to 1000000 and idles the
// sequencer; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module float_to_best_rational (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [63:0]         req_value_bits,
   output logic                     rsp_strobe,
   output logic signed [63:0]       rsp_numerator,
   output ftbr_pkg::den_type        rsp_denominator,
   output logic                     rsp_error,
   input  wire logic                csr_wen,
   input  wire ftbr_pkg::den_type   csr_wdata
);
   import ftbr_pkg::*;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_FLOOR   = 5'd1;
   localparam logic [4:0] ST_FRAC_W  = 5'd2;
   localparam logic [4:0] ST_KMUL    = 5'd3;
   localparam logic [4:0] ST_KMUL_W  = 5'd4;
   localparam logic [4:0] ST_HMUL    = 5'd5;
   localparam logic [4:0] ST_HMUL_W  = 5'd6;
   localparam logic [4:0] ST_RDIV    = 5'd7;
   localparam logic [4:0] ST_RDIV_W  = 5'd8;
   localparam logic [4:0] ST_RNORM   = 5'd9;
   localparam logic [4:0] ST_RNORM_W = 5'd10;
   localparam logic [4:0] ST_CVH     = 5'd11;
   localparam logic [4:0] ST_CVH_W   = 5'd12;
   localparam logic [4:0] ST_CVK     = 5'd13;
   localparam logic [4:0] ST_CVK_W   = 5'd14;
   localparam logic [4:0] ST_QDIV    = 5'd15;
   localparam logic [4:0] ST_QDIV_W  = 5'd16;
   localparam logic [4:0] ST_QNORM   = 5'd17;
   localparam logic [4:0] ST_QNORM_W = 5'd18;
   localparam logic [4:0] ST_SUB     = 5'd19;
   localparam logic [4:0] ST_SUB_W   = 5'd20;
   localparam logic [4:0] ST_DONE    = 5'd21;

   logic [4:0]           state_ff, state_in;
   den_type              lim_ff, lim_in;
   dbl_mag_type          x_ff, x_in;
   dbl_mag_type          orig_ff, orig_in;
   dbl_mag_type          frac_ff, frac_in;
   dbl_mag_type          hd_ff, hd_in;
   dbl_mag_type          kd_ff, kd_in;
   dbl_mag_type          q_ff, q_in;
   dbl_mag_type          d0_ff, d0_in;
   logic [63:0]          h0_ff, h0_in, h1_ff, h1_in;
   den_type              k0_ff, k0_in, k1_ff, k1_in, k2_ff, k2_in;
   logic [TERM_BITS-1:0] a_ff, a_in;
   logic [63:0]          rh_ff, rh_in;
   den_type              rk_ff, rk_in;
   logic                 err_ff, err_in;
   logic                 neg_ff, neg_in;
   logic                 sel_ff, sel_in;
   logic                 strobe_ff, strobe_in;
   logic [63:0]          num_ff, num_in;
   den_type              den_ff, den_in;
   logic                 rerr_ff, rerr_in;

   logic        norm_go, norm_done;
   logic [63:0] norm_v;
   exp_type     norm_e;
   dbl_mag_type norm_res;
   logic        div_go, div_done, div_sticky;
   mant_type    div_num, div_den;
   logic [54:0] div_quo;
   logic        mac_go, mac_done;
   logic [63:0] mac_b, mac_c, mac_res;

   den_type     lim_eff;
   logic [10:0] xe;
   mant_type    xm;
   logic [4:0]  int_e;
   logic [5:0]  fl_sh;
   logic [TERM_BITS-1:0] fl_a;
   mant_type    fl_frac;
   logic        x_small, x_huge;
   logic [63:0] hsel;
   den_type     ksel;
   logic        q_ge;
   dbl_mag_type big, small_v;
   logic [10:0] ed;
   mant_type    ms;
   logic [55:0] ms3, sh_part, sm, sub_diff;
   logic        lost;

   always_comb begin
      lim_eff = (lim_ff == '0) ? 31'd1 : lim_ff;
      xe = x_ff[62:52];
      xm = {1'b1, x_ff[51:0]};
      int_e = 5'(xe - EXP_BIAS);
      fl_sh = 6'd52 - {1'b0, int_e};
      fl_a = TERM_BITS'(xm >> fl_sh);
      fl_frac = xm & ((53'd1 << fl_sh) - 53'd1);
      x_small = xe < EXP_BIAS;
      x_huge = xe >= EXP_HUGE;
      hsel = sel_ff ? h1_ff : h0_ff;
      ksel = sel_ff ? k1_ff : k0_ff;
      q_ge = q_ff >= orig_ff;
      big = q_ge ? q_ff : orig_ff;
      small_v = q_ge ? orig_ff : q_ff;
      ed = big[62:52] - small_v[62:52];
      ms = (small_v == '0) ? '0 : {1'b1, small_v[51:0]};
      ms3 = {ms, 3'b000};
      sh_part = ms3 >> ed[5:0];
      lost = (sh_part << ed[5:0]) != ms3;
      if (ed >= 11'd56) begin
         sm = {55'd0, |ms};
      end else begin
         sm = sh_part | {55'd0, lost};
      end
      sub_diff = {1'b1, big[51:0], 3'b000} - sm;
   end

   always_comb begin
      norm_go = 1'b0;
      norm_v = '0;
      norm_e = '0;
      div_go = 1'b0;
      div_num = {1'b1, hd_ff[51:0]};
      div_den = {1'b1, kd_ff[51:0]};
      mac_go = 1'b0;
      mac_b = h1_ff;
      mac_c = h0_ff;
      state_in = state_ff;
      lim_in = csr_wen ? csr_wdata : lim_ff;
      x_in = x_ff;
      orig_in = orig_ff;
      frac_in = frac_ff;
      hd_in = hd_ff;
      kd_in = kd_ff;
      q_in = q_ff;
      d0_in = d0_ff;
      h0_in = h0_ff;
      h1_in = h1_ff;
      k0_in = k0_ff;
      k1_in = k1_ff;
      k2_in = k2_ff;
      a_in = a_ff;
      rh_in = rh_ff;
      rk_in = rk_ff;
      err_in = err_ff;
      neg_in = neg_ff;
      sel_in = sel_ff;
      strobe_in = 1'b0;
      num_in = num_ff;
      den_in = den_ff;
      rerr_in = rerr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in = req_value_bits[62:0];
               orig_in = req_value_bits[62:0];
               neg_in = req_value_bits[63];
               h0_in = 64'd0;
               h1_in = 64'd1;
               k0_in = 31'd1;
               k1_in = 31'd0;
               rh_in = 64'd0;
               rk_in = '0;
               if (req_value_bits[62:0] >= MAG_LIMIT) begin
                  err_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  err_in = 1'b0;
                  state_in = ST_FLOOR;
               end
            end
         end
         ST_FLOOR: begin
            if (x_small) begin
               a_in = '0;
               frac_in = x_ff;
               state_in = ST_KMUL;
            end else if (x_huge) begin
               a_in = TERM_CLAMP;
               frac_in = '0;
               state_in = ST_KMUL;
            end else begin
               a_in = fl_a;
               norm_go = 1'b1;
               norm_v = {fl_frac, 11'd0};
               norm_e = exp_type'({8'd0, int_e});
               state_in = ST_FRAC_W;
            end
         end
         ST_FRAC_W: begin
            if (norm_done) begin
               frac_in = norm_res;
               state_in = ST_KMUL;
            end
         end
         ST_KMUL: begin
            mac_go = 1'b1;
            mac_b = {33'd0, k1_ff};
            mac_c = {33'd0, k0_ff};
            state_in = ST_KMUL_W;
         end
         ST_KMUL_W: begin
            if (mac_done) begin
               if (mac_res > {33'd0, lim_eff}) begin
                  if (k0_ff == '0) begin
                     rh_in = h1_ff;
                     rk_in = k1_ff;
                     state_in = ST_DONE;
                  end else begin
                     sel_in = 1'b0;
                     state_in = ST_CVH;
                  end
               end else begin
                  k2_in = mac_res[30:0];
                  state_in = ST_HMUL;
               end
            end
         end
         ST_HMUL: begin
            mac_go = 1'b1;
            state_in = ST_HMUL_W;
         end
         ST_HMUL_W: begin
            if (mac_done) begin
               h0_in = h1_ff;
               h1_in = mac_res;
               k0_in = k1_ff;
               k1_in = k2_ff;
               rh_in = mac_res;
               rk_in = k2_ff;
               if (frac_ff < EPS_REMAINDER) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RDIV;
               end
            end
         end
         ST_RDIV: begin
            div_go = 1'b1;
            div_num = {1'b1, 52'd0};
            div_den = {1'b1, frac_ff[51:0]};
            state_in = ST_RDIV_W;
         end
         ST_RDIV_W: begin
            if (div_done) begin
               state_in = ST_RNORM;
            end
         end
         ST_RNORM: begin
            norm_go = 1'b1;
            norm_v = {div_quo, div_sticky, 8'd0};
            norm_e = EXP_BIAS_S - exp_type'({2'b00, frac_ff[62:52]});
            state_in = ST_RNORM_W;
         end
         ST_RNORM_W: begin
            if (norm_done) begin
               x_in = norm_res;
               state_in = ST_FLOOR;
            end
         end
         ST_CVH: begin
            norm_go = 1'b1;
            norm_v = hsel;
            norm_e = 13'sd63;
            state_in = ST_CVH_W;
         end
         ST_CVH_W: begin
            if (norm_done) begin
               hd_in = norm_res;
               state_in = ST_CVK;
            end
         end
         ST_CVK: begin
            norm_go = 1'b1;
            norm_v = {33'd0, ksel};
            norm_e = 13'sd63;
            state_in = ST_CVK_W;
         end
         ST_CVK_W: begin
            if (norm_done) begin
               kd_in = norm_res;
               if (hd_ff == '0) begin
                  q_in = '0;
                  state_in = ST_SUB;
               end else begin
                  state_in = ST_QDIV;
               end
            end
         end
         ST_QDIV: begin
            div_go = 1'b1;
            state_in = ST_QDIV_W;
         end
         ST_QDIV_W: begin
            if (div_done) begin
               state_in = ST_QNORM;
            end
         end
         ST_QNORM: begin
            norm_go = 1'b1;
            norm_v = {div_quo, div_sticky, 8'd0};
            norm_e = exp_type'({2'b00, hd_ff[62:52]}) - exp_type'({2'b00, kd_ff[62:52]});
            state_in = ST_QNORM_W;
         end
         ST_QNORM_W: begin
            if (norm_done) begin
               q_in = norm_res;
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            norm_go = 1'b1;
            norm_v = {sub_diff, 8'd0};
            norm_e = exp_type'({2'b00, big[62:52]}) - EXP_BIAS_S;
            state_in = ST_SUB_W;
         end
         ST_SUB_W: begin
            if (norm_done) begin
               if (!sel_ff) begin
                  d0_in = norm_res;
                  sel_in = 1'b1;
                  state_in = ST_CVH;
               end else begin
                  if (d0_ff < norm_res) begin
                     rh_in = h0_ff;
                     rk_in = k0_ff;
                  end else begin
                     rh_in = h1_ff;
                     rk_in = k1_ff;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            num_in = neg_ff ? (64'd0 - rh_ff) : rh_ff;
            den_in = rk_ff;
            rerr_in = err_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   ftbr_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .start    (norm_go),
      .in_value (norm_v),
      .in_exp   (norm_e),
      .done     (norm_done),
      .result   (norm_res)
   );

   ftbr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .num_mant (div_num),
      .den_mant (div_den),
      .done     (div_done),
      .quotient (div_quo),
      .sticky   (div_sticky)
   );

   ftbr_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .start  (mac_go),
      .mul_a  (a_ff),
      .mul_b  (mac_b),
      .add_c  (mac_c),
      .done   (mac_done),
      .result (mac_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lim_ff <= DEN_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lim_ff <= lim_in;
         strobe_ff <= strobe_in;
      end
      x_ff <= x_in;
      orig_ff <= orig_in;
      frac_ff <= frac_in;
      hd_ff <= hd_in;
      kd_ff <= kd_in;
      q_ff <= q_in;
      d0_ff <= d0_in;
      h0_ff <= h0_in;
      h1_ff <= h1_in;
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      k2_ff <= k2_in;
      a_ff <= a_in;
      rh_ff <= rh_in;
      rk_ff <= rk_in;
      err_ff <= err_in;
      neg_ff <= neg_in;
      sel_ff <= sel_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rerr_ff <= rerr_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_numerator = num_ff;
   assign rsp_denominator = den_ff;
   assign rsp_error = rerr_ff;

endmodule

`default_nettype wire
